### src/qpd_pkg.sv
// ----------------------------------------------------------------------------
// Quoted-printable decoder package
// Character codes, escape phase codes and the hex nibble lookup shared by
// the decoder logic.
// ----------------------------------------------------------------------------
package qpd_pkg;

    // Character codes that steer the decoder.
    localparam logic [7:0] QP_EQUALS     = 8'h3D;
    localparam logic [7:0] QP_CR         = 8'h0D;
    localparam logic [7:0] QP_LF         = 8'h0A;
    localparam logic [7:0] QP_NUL        = 8'h00;
    localparam logic [7:0] QP_BAD_NIBBLE = 8'hFF;

    // Escape phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;  // no escape pending
    localparam logic [1:0] PH_EQ   = 2'd1;  // '=' seen
    localparam logic [1:0] PH_HELD = 2'd2;  // '=' and one byte seen

    // Width of the visible byte count.
    localparam int unsigned OUT_COUNT_BITS = 16;
    localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = 16'hFFFF;

    typedef logic [7:0] byte_t;

    // Hex digit value in either case, all ones for any other code.
    function automatic byte_t nib_of(input byte_t c);
        byte_t r;
        begin
            r = QP_BAD_NIBBLE;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = c - 8'h37;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = c - 8'h57;
            end
            return r;
        end
    endfunction

    // Joins two escape characters into one byte, modulo 256.
    function automatic byte_t combine(input byte_t hi, input byte_t lo);
        byte_t nh;
        byte_t nl;
        begin
            nh = nib_of(hi);
            nl = nib_of(lo);
            return {nh[3:0], 4'b0000} + nl;
        end
    endfunction

endpackage

### src/quoted_printable_decoder.sv
// ----------------------------------------------------------------------------
// Quoted-printable decoder
// Turns a quoted-printable byte stream into decoded bytes, one word in and
// one word out, with a saturating count of decoded bytes per text.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready) carries one encoded byte per word,
// with in_last marking the final byte of a text. The result channel
// (result_valid, result_ready) returns exactly one word for every input word:
// out_valid tells whether a decoded byte came out (escape leaders and soft
// line breaks give none), out_last copies in_last and out_count holds the
// decoded bytes of the text so far.
// An input word passes through the input register and then the result
// register; result_valid rises once the word moves from the input register
// into the result register, which can wait on a stalled receiver.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single decode step between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word, after which in_ready drops.
// Reset empties both registers, clears the escape phase, the held character
// and the byte count. A word with in_last also clears them after it.
// ----------------------------------------------------------------------------
module quoted_printable_decoder
    import qpd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [7:0]                out_byte,
    output logic                      out_valid,
    output logic                      out_last,
    output logic [OUT_COUNT_BITS-1:0] out_count
);

    // Input register stage.
    logic       s1_valid_reg;
    byte_t      s1_byte_reg;
    logic       s1_last_reg;

    // Decoder state.
    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    byte_t                 held_reg;
    byte_t                 held_next;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_new;

    // Result register stage.
    logic                      res_valid_reg;
    byte_t                     out_byte_reg;
    logic                      out_valid_reg;
    logic                      out_last_reg;
    logic [OUT_COUNT_BITS-1:0] out_count_reg;

    logic                      s1_advance;
    logic                      dec_valid;
    byte_t                     dec_byte;
    logic [OUT_COUNT_BITS-1:0] shown;

    // Flow control: the result register loads from a full input register whenever it is empty or drained.
    assign s1_advance = s1_valid_reg && (!res_valid_reg || result_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    // Escape decode for the word in the input register.
    always_comb
    begin
        dec_valid  = 1'b0;
        dec_byte   = QP_NUL;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_EQ:
            begin
                if (s1_last_reg)
                begin
                    dec_valid = 1'b1;
                    dec_byte  = combine(s1_byte_reg, QP_NUL);
                end
                else
                begin
                    held_next  = s1_byte_reg;
                    phase_next = PH_HELD;
                end
            end
            PH_HELD:
            begin
                if (!(held_reg == QP_CR && s1_byte_reg == QP_LF))
                begin
                    dec_valid = 1'b1;
                    dec_byte  = combine(held_reg, s1_byte_reg);
                end
            end
            default:
            begin
                if (s1_byte_reg == QP_EQUALS)
                begin
                    if (s1_last_reg)
                    begin
                        dec_valid = 1'b1;
                        dec_byte  = combine(QP_NUL, QP_NUL);
                    end
                    else
                    begin
                        phase_next = PH_EQ;
                    end
                end
                else
                begin
                    dec_valid = 1'b1;
                    dec_byte  = s1_byte_reg;
                end
            end
        endcase
    end

    // Saturating count including this word's byte.
    assign total_new = (dec_valid && !(&total_reg))
                       ? total_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1}
                       : total_reg;

    // The visible count saturates at its own width when the internal count is wider, else follows it.
    generate
        if (COUNT_BITS > OUT_COUNT_BITS)
        begin : g_wide_count
            assign shown = (|total_new[COUNT_BITS-1:OUT_COUNT_BITS])
                           ? OUT_COUNT_MAX : total_new[OUT_COUNT_BITS-1:0];
        end
        else if (COUNT_BITS == OUT_COUNT_BITS)
        begin : g_same_count
            assign shown = total_new;
        end
        else
        begin : g_narrow_count
            assign shown = {{(OUT_COUNT_BITS-COUNT_BITS){1'b0}}, total_new};
        end
    endgenerate

    // State update; the end of a text starts the next one from scratch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= QP_NUL;
            total_reg <= '0;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                phase_reg <= PH_IDLE;
                held_reg  <= QP_NUL;
                total_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                total_reg <= total_new;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_byte_reg  <= dec_byte;
            out_valid_reg <= dec_valid;
            out_last_reg  <= s1_last_reg;
            out_count_reg <= shown;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_valid    = out_valid_reg;
    assign out_last     = out_last_reg;
    assign out_count    = out_count_reg;

    // A word without a decoded byte always shows a zero byte.
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_valid_reg) |-> (out_byte_reg == QP_NUL))
        else $error("result word without a decoded byte carries a nonzero byte");

    // The final word of a text clears the decoder state.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (total_reg == '0 && phase_reg == PH_IDLE))
        else $error("decoder state not cleared after the final word of a text");

    // A decoded byte inside a text advances the count by one below saturation.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && dec_valid && !s1_last_reg && !(&total_reg))
        |=> (total_reg == $past(total_reg) + {{(COUNT_BITS-1){1'b0}}, 1'b1}))
        else $error("byte count did not advance on a decoded byte");

    // An empty result register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> in_ready)
        else $error("input stalled while the result register is empty");

endmodule
